// ----- hw/rtl/tsaa_pkg.sv -----
// Package for the tree short address allocator.
// Holds the configuration struct, register indexes, sequencer states and constants.
// No dependencies.
package tsaa_pkg;

    localparam int MAX_CHILD_SLOTS_DEF = 32;
    localparam int DEPTH_LIMIT_DEF     = 15;

    localparam logic [15:0] NO_ADDRESS = 16'hffff;
    localparam logic [15:0] MAX_ADDR   = 16'hfffe;
    localparam logic [16:0] CSKIP_CAP  = 17'h10000;

    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    typedef struct packed {
        logic        tree_mode;
        logic [3:0]  max_depth;
        logic [5:0]  max_children;
        logic [5:0]  max_routers;
        logic [3:0]  own_depth;
        logic [15:0] own_address;
        logic [15:0] address_increment;
    } t_cfg;

    typedef enum logic [2:0] {
        REG_TREE_MODE    = 3'd0,
        REG_MAX_DEPTH    = 3'd1,
        REG_MAX_CHILDREN = 3'd2,
        REG_MAX_ROUTERS  = 3'd3,
        REG_OWN_DEPTH    = 3'd4,
        REG_OWN_ADDRESS  = 3'd5,
        REG_ADDR_INCR    = 3'd6
    } t_reg_idx;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_POW  = 5'b00010,
        S_CSK  = 5'b00100,
        S_FIND = 5'b01000,
        S_ADDR = 5'b10000
    } t_state;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_LOAD  = 1'b1;

endpackage

// ----- hw/rtl/tsaa_cfg_regs.sv -----
// Configuration register file with an APB-style write and read port.
// Depends on tsaa_pkg for the configuration struct and register indexes.
module tsaa_cfg_regs import tsaa_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[APB_AW-1:2]);
    assign wr_en   = psel & penable & pwrite;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tree_mode         <= 1'b1;
            r_cfg.max_depth         <= 4'd5;
            r_cfg.max_children      <= 6'd20;
            r_cfg.max_routers       <= 6'd6;
            r_cfg.own_depth         <= 4'd0;
            r_cfg.own_address       <= 16'd0;
            r_cfg.address_increment <= 16'd1;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_TREE_MODE:    r_cfg.tree_mode         <= pwdata[0];
                REG_MAX_DEPTH:    r_cfg.max_depth         <= pwdata[3:0];
                REG_MAX_CHILDREN: r_cfg.max_children      <= pwdata[5:0];
                REG_MAX_ROUTERS:  r_cfg.max_routers       <= pwdata[5:0];
                REG_OWN_DEPTH:    r_cfg.own_depth         <= pwdata[3:0];
                REG_OWN_ADDRESS:  r_cfg.own_address       <= pwdata[15:0];
                REG_ADDR_INCR:    r_cfg.address_increment <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_TREE_MODE:    prdata = {31'd0, r_cfg.tree_mode};
            REG_MAX_DEPTH:    prdata = {28'd0, r_cfg.max_depth};
            REG_MAX_CHILDREN: prdata = {26'd0, r_cfg.max_children};
            REG_MAX_ROUTERS:  prdata = {26'd0, r_cfg.max_routers};
            REG_OWN_DEPTH:    prdata = {28'd0, r_cfg.own_depth};
            REG_OWN_ADDRESS:  prdata = {16'd0, r_cfg.own_address};
            REG_ADDR_INCR:    prdata = {16'd0, r_cfg.address_increment};
            default:          prdata = '0;
        endcase
    end

endmodule

// ----- hw/rtl/tree_short_address_allocator.sv -----
// Top level of the tree short address allocator: sequencer around one shared multiplier.
// Depends on tsaa_pkg and tsaa_cfg_regs.
//
// Channel   Direction  Handshake           Payload
// request   in         i_valid / o_stall   i_op, i_is_router, i_occupied_slots,
//                                          i_pool_start, i_pool_count
// result    out        o_valid / i_stall   o_address, o_granted, o_permit_cleared
// config    in         psel/penable/pwrite paddr, pwdata, prdata, pready
//
// Loads, pool allocations and requests at the maximum depth are answered from S_IDLE.
// A tree request runs t = max_depth - own_depth - 1 power steps (at most 14) and then
// S_CSK, S_FIND, S_ADDR; the 17 x 6 multiplier forms Cskip one power step per cycle.
// One request is in work at a time; o_stall is high while the sequencer is busy
// or while a result waits under i_stall. Reset is synchronous and active low.
module tree_short_address_allocator import tsaa_pkg::*; #(
    parameter int MAX_CHILD_SLOTS = MAX_CHILD_SLOTS_DEF,
    parameter int DEPTH_LIMIT     = DEPTH_LIMIT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_op,
    input  logic              i_is_router,
    input  logic [31:0]       i_occupied_slots,
    input  logic [15:0]       i_pool_start,
    input  logic [15:0]       i_pool_count,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [15:0]       o_address,
    output logic              o_granted,
    output logic              o_permit_cleared,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int IDX_W = (MAX_CHILD_SLOTS > 1) ? $clog2(MAX_CHILD_SLOTS) : 1;

    t_cfg   cfg;
    t_state r_state;

    logic                       r_out_valid;
    logic [15:0]                r_address;
    logic                       r_granted;
    logic                       r_cleared;
    logic [15:0]                r_next_pool;
    logic [15:0]                r_pool_rem;
    logic [3:0]                 r_cnt;
    logic [16:0]                r_sum;
    logic [16:0]                r_cskip;
    logic [MAX_CHILD_SLOTS-1:0] r_free;
    logic                       r_is_router;
    logic                       r_found;
    logic [IDX_W-1:0]           r_idx;

    logic                       accept;
    logic [16:0]                mul_a;
    logic [5:0]                 mul_b;
    logic [22:0]                prod;
    logic [23:0]                prod_inc;
    logic [16:0]                prod_sat;
    logic [3:0]                 depth_gap;
    logic [3:0]                 pow_cnt;
    logic [MAX_CHILD_SLOTS+31:0] occ_pad;
    logic [5:0]                 slot_first;
    logic [5:0]                 slot_n;
    logic [6:0]                 slot_end;
    logic [MAX_CHILD_SLOTS-1:0] free_mask;
    logic                       pe_found;
    logic [IDX_W-1:0]           pe_idx;
    logic [5:0]                 end_j;
    logic [23:0]                tree_addr;

    tsaa_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign o_stall = !((r_state == S_IDLE) && (!r_out_valid || !i_stall));
    assign accept  = i_valid && !o_stall;

    assign o_valid          = r_out_valid;
    assign o_address        = r_address;
    assign o_granted        = r_granted;
    assign o_permit_cleared = r_cleared;

    // Shared multiplier: power steps, the Cskip product and the slot offset.
    always_comb begin
        mul_a = (r_state == S_ADDR) ? r_cskip : r_sum;
        unique case (r_state)
            S_CSK:   mul_b = cfg.max_children;
            S_ADDR:  mul_b = r_is_router ? 6'(r_idx) : cfg.max_routers;
            default: mul_b = cfg.max_routers;
        endcase
    end

    assign prod     = mul_a * mul_b;
    assign prod_inc = {1'b0, prod} + 24'd1;
    assign prod_sat = (prod_inc > {7'd0, CSKIP_CAP}) ? CSKIP_CAP : prod_inc[16:0];

    assign depth_gap = cfg.max_depth - cfg.own_depth - 4'd1;
    assign pow_cnt   = (depth_gap > 4'(DEPTH_LIMIT)) ? 4'(DEPTH_LIMIT) : depth_gap;

    // Slots that may be handed out for this request.
    assign occ_pad    = {{MAX_CHILD_SLOTS{1'b0}}, i_occupied_slots};
    assign slot_first = i_is_router ? 6'd0 : cfg.max_routers;
    assign slot_n     = i_is_router ? cfg.max_routers :
                        ((cfg.max_children > cfg.max_routers) ?
                         (cfg.max_children - cfg.max_routers) : 6'd0);
    assign slot_end   = {1'b0, slot_first} + {1'b0, slot_n};

    always_comb begin
        for (int k = 0; k < MAX_CHILD_SLOTS; k++) begin
            free_mask[k] = (7'(k) >= {1'b0, slot_first}) && (7'(k) < slot_end)
                           && !occ_pad[k];
        end
    end

    always_comb begin
        pe_found = 1'b0;
        pe_idx   = '0;
        for (int k = MAX_CHILD_SLOTS - 1; k >= 0; k--) begin
            if (r_free[k]) begin
                pe_found = 1'b1;
                pe_idx   = IDX_W'(k);
            end
        end
    end

    assign end_j     = 6'(r_idx) - cfg.max_routers;
    assign tree_addr = {8'd0, cfg.own_address} + 24'd1 + {1'b0, prod}
                       + (r_is_router ? 24'd0 : {18'd0, end_j});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_next_pool <= 16'd0;
            r_pool_rem  <= 16'd0;
        end else begin
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_free      <= free_mask;
                        r_is_router <= i_is_router;
                        r_sum       <= 17'd0;
                        r_cnt       <= pow_cnt;
                        if (i_op == OP_LOAD) begin
                            r_next_pool <= i_pool_start;
                            r_pool_rem  <= i_pool_count;
                            r_address   <= NO_ADDRESS;
                            r_granted   <= 1'b0;
                            r_cleared   <= 1'b0;
                            r_out_valid <= 1'b1;
                        end else if (!cfg.tree_mode) begin
                            if (r_pool_rem != 16'd0) begin
                                r_address   <= r_next_pool;
                                r_granted   <= 1'b1;
                                r_cleared   <= 1'b0;
                                r_pool_rem  <= r_pool_rem - 16'd1;
                                r_next_pool <= r_next_pool + cfg.address_increment;
                            end else begin
                                r_address <= NO_ADDRESS;
                                r_granted <= 1'b0;
                                r_cleared <= 1'b1;
                            end
                            r_out_valid <= 1'b1;
                        end else if (cfg.own_depth >= cfg.max_depth) begin
                            r_address   <= NO_ADDRESS;
                            r_granted   <= 1'b0;
                            r_cleared   <= 1'b1;
                            r_out_valid <= 1'b1;
                        end else if (pow_cnt == 4'd0) begin
                            r_state <= S_CSK;
                        end else begin
                            r_state <= S_POW;
                        end
                    end
                end
                S_POW: begin
                    r_sum <= prod_sat;
                    r_cnt <= r_cnt - 4'd1;
                    if (r_cnt == 4'd1) begin
                        r_state <= S_CSK;
                    end
                end
                S_CSK: begin
                    r_cskip <= prod_sat;
                    r_state <= S_FIND;
                end
                S_FIND: begin
                    r_found <= pe_found;
                    r_idx   <= pe_idx;
                    r_state <= S_ADDR;
                end
                S_ADDR: begin
                    if (r_found && (tree_addr <= {8'd0, MAX_ADDR})) begin
                        r_address <= tree_addr[15:0];
                        r_granted <= 1'b1;
                    end else begin
                        r_address <= NO_ADDRESS;
                        r_granted <= 1'b0;
                    end
                    r_cleared   <= 1'b0;
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- dv/tree_short_address_allocator_tb.sv -----
// Self-checking testbench for tree_short_address_allocator: directed and random join requests.
// An in-bench predictor tracks the configuration and pool state to check every result.
// Depends on tsaa_pkg and the allocator RTL.
module tb import tsaa_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 24;
    localparam int RANDOM_PHASES = 20;
    localparam int PHASE_ITEMS   = 61;

    typedef struct packed {
        logic [15:0] address;
        logic        granted;
        logic        permit_cleared;
    } t_grant;

    class allocation_ledger;
        t_cfg        cfg;
        logic [15:0] pool_next;
        logic [15:0] pool_left;
        t_grant      pending[$];
        int unsigned n_errors;
        int unsigned n_checked;
        int unsigned n_granted;
        int unsigned n_cleared;
        int unsigned n_loads;

        function new();
            cfg = '{tree_mode: 1'b1, max_depth: 4'd5, max_children: 6'd20, max_routers: 6'd6,
                    own_depth: 4'd0, own_address: 16'h0000, address_increment: 16'h0001};
            pool_next = '0;
            pool_left = '0;
            n_errors  = 0;
            n_checked = 0;
            n_granted = 0;
            n_cleared = 0;
            n_loads   = 0;
        endfunction

        function int unsigned cskip_span();
            int unsigned t;
            int unsigned sum;
            int unsigned c;
            if (cfg.own_depth >= cfg.max_depth) return 0;
            t   = cfg.max_depth - cfg.own_depth - 1;
            sum = 0;
            for (int k = 0; k < t && k < DEPTH_LIMIT_DEF; k++) begin
                sum = sum * cfg.max_routers + 1;
                if (sum > CSKIP_CAP) sum = 32'(CSKIP_CAP);
            end
            c = 1 + cfg.max_children * sum;
            return (c > CSKIP_CAP) ? 32'(CSKIP_CAP) : c;
        endfunction

        function void log_request(logic op, logic is_router, logic [31:0] occ,
                                  logic [15:0] start, logic [15:0] count);
            t_grant          g;
            int unsigned     cs;
            int unsigned     n;
            int unsigned     first;
            int unsigned     idx;
            longint unsigned base;
            longint unsigned step;
            longint unsigned a;
            g = '{address: NO_ADDRESS, granted: 1'b0, permit_cleared: 1'b0};
            if (op == OP_LOAD) begin
                pool_next = start;
                pool_left = count;
                n_loads++;
            end else if (cfg.tree_mode) begin
                cs = cskip_span();
                if (cs == 0) begin
                    g.permit_cleared = 1'b1;
                end else begin
                    base = 64'(cfg.own_address) + 1;
                    if (is_router) begin
                        n     = 32'(cfg.max_routers);
                        first = 0;
                        step  = 64'(cs);
                    end else begin
                        n     = (cfg.max_children > cfg.max_routers) ?
                                32'(cfg.max_children - cfg.max_routers) : 0;
                        first = 32'(cfg.max_routers);
                        base  = base + 64'(cs) * cfg.max_routers;
                        step  = 64'd1;
                    end
                    for (int unsigned i = 0; i < n; i++) begin
                        idx = first + i;
                        if (idx >= MAX_CHILD_SLOTS_DEF) break;
                        a = base + 64'(i) * step;
                        if (a > MAX_ADDR) break;
                        if (!occ[idx]) begin
                            g.address = a[15:0];
                            g.granted = 1'b1;
                            break;
                        end
                    end
                end
            end else if (pool_left != 0) begin
                g.address = pool_next;
                g.granted = 1'b1;
                pool_left = pool_left - 16'd1;
                pool_next = pool_next + cfg.address_increment;
            end else begin
                g.permit_cleared = 1'b1;
            end
            pending.push_back(g);
        endfunction

        function void check_grant(logic [15:0] address, logic granted, logic cleared);
            t_grant want;
            if (pending.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected result: address %h granted %b permit_cleared %b",
                         $time, address, granted, cleared);
                return;
            end
            want = pending.pop_front();
            n_checked++;
            if (want.granted) n_granted++;
            if (want.permit_cleared) n_cleared++;
            if (address !== want.address || granted !== want.granted ||
                cleared !== want.permit_cleared) begin
                n_errors++;
                $display({"%0t: mismatch: expected address %h granted %b permit_cleared %b,",
                          " got address %h granted %b permit_cleared %b"},
                         $time, want.address, want.granted, want.permit_cleared,
                         address, granted, cleared);
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic              i_op;
    logic              i_is_router;
    logic [31:0]       i_occupied_slots;
    logic [15:0]       i_pool_start;
    logic [15:0]       i_pool_count;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [15:0]       o_address;
    logic              o_granted;
    logic              o_permit_cleared;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    allocation_ledger ledger = new();
    int send_odds  = 0;
    int stall_odds = 0;
    int stall_run  = 0;
    logic stall_on = 1'b0;
    int n_settings = 0;

    tree_short_address_allocator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_op            (i_op),
        .i_is_router     (i_is_router),
        .i_occupied_slots(i_occupied_slots),
        .i_pool_start    (i_pool_start),
        .i_pool_count    (i_pool_count),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_address       (o_address),
        .o_granted       (o_granted),
        .o_permit_cleared(o_permit_cleared),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        if (stall_run == 0) begin
            if (stall_odds != 0 && $urandom_range(0, 7) < stall_odds) begin
                stall_on  = 1'b1;
                stall_run = $urandom_range(1, 19);
            end else begin
                stall_on  = 1'b0;
                stall_run = $urandom_range(1, 25);
            end
        end
        stall_run = stall_run - 1;
        i_stall <= stall_on;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                ledger.log_request(i_op, i_is_router, i_occupied_slots, i_pool_start,
                                   i_pool_count);
            end
            if (o_valid && !i_stall) begin
                ledger.check_grant(o_address, o_granted, o_permit_cleared);
            end
        end
    end

    task automatic send_request(logic op, logic rtr, logic [31:0] occ, logic [15:0] start,
                                logic [15:0] count);
        if (send_odds != 0 && $urandom_range(0, 7) < send_odds) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        i_valid          <= 1'b1;
        i_op             <= op;
        i_is_router      <= rtr;
        i_occupied_slots <= occ;
        i_pool_start     <= start;
        i_pool_count     <= count;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic ask(logic rtr, logic [31:0] occ);
        send_request(OP_ALLOC, rtr, occ, 16'($urandom), 16'($urandom));
    endtask

    task automatic load_pool(logic [15:0] start, logic [15:0] count);
        send_request(OP_LOAD, 1'($urandom), $urandom, start, count);
    endtask

    task automatic hold_until_drained();
        i_valid <= 1'b0;
        while (ledger.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic apb_write(t_reg_idx idx, logic [31:0] data);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic apply_setting(t_cfg c);
        hold_until_drained();
        apb_write(REG_TREE_MODE,    32'(c.tree_mode));
        apb_write(REG_MAX_DEPTH,    32'(c.max_depth));
        apb_write(REG_MAX_CHILDREN, 32'(c.max_children));
        apb_write(REG_MAX_ROUTERS,  32'(c.max_routers));
        apb_write(REG_OWN_DEPTH,    32'(c.own_depth));
        apb_write(REG_OWN_ADDRESS,  32'(c.own_address));
        apb_write(REG_ADDR_INCR,    32'(c.address_increment));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        ledger.cfg = c;
        n_settings++;
    endtask

    function automatic t_cfg random_setting();
        t_cfg c;
        c.tree_mode = ($urandom_range(0, 3) != 0);
        case ($urandom_range(0, 3))
            0: c.max_depth = 4'd15;
            1: c.max_depth = 4'($urandom_range(0, 2));
            default: c.max_depth = 4'($urandom_range(0, 15));
        endcase
        c.own_depth = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(0, 15)) :
                                                    4'($urandom_range(0, c.max_depth));
        c.max_children = ($urandom_range(0, 3) == 0) ? 6'd32 : 6'($urandom_range(0, 32));
        c.max_routers  = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 32)) :
                                                       6'($urandom_range(0, c.max_children));
        case ($urandom_range(0, 3))
            0: c.own_address = 16'h0000;
            1: c.own_address = 16'($urandom_range(16'hff00, 16'hffff));
            default: c.own_address = 16'($urandom);
        endcase
        case ($urandom_range(0, 4))
            0: c.address_increment = 16'h0000;
            1: c.address_increment = 16'h0001;
            2: c.address_increment = 16'hffff;
            default: c.address_increment = 16'($urandom);
        endcase
        return c;
    endfunction

    task automatic random_request();
        int          fill;
        logic [31:0] occ;
        if ($urandom_range(0, 15) < (ledger.cfg.tree_mode ? 1 : 3)) begin
            load_pool(16'($urandom), ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                                                                  16'($urandom_range(0, 6)));
        end else begin
            fill = $urandom_range(0, 32);
            occ  = (fill == 32) ? 32'hffff_ffff : (32'd1 << fill) - 32'd1;
            case ($urandom_range(0, 3))
                0: occ = $urandom;
                1: occ = occ | ($urandom & $urandom);
                default: ;
            endcase
            ask(1'($urandom_range(0, 1)), occ);
        end
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_valid          = 1'b0;
        i_op             = OP_ALLOC;
        i_is_router      = 1'b0;
        i_occupied_slots = '0;
        i_pool_start     = '0;
        i_pool_count     = '0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        apply_setting(t_cfg'{1'b1, 4'd5, 6'd20, 6'd6, 4'd0, 16'h0000, 16'h0001});
        ask(1'b1, 32'h0000_0000);
        ask(1'b1, 32'h0000_001f);
        ask(1'b1, 32'h0000_003f);
        ask(1'b0, 32'h0000_003f);
        ask(1'b0, 32'hffff_ffff);
        send_request(OP_LOAD, 1'b1, 32'hffff_ffff, 16'hffff, 16'hffff);

        apply_setting(t_cfg'{1'b1, 4'd3, 6'd20, 6'd6, 4'd3, 16'h1234, 16'h0001});
        ask(1'b1, 32'h0000_0000);
        ask(1'b0, 32'h0000_0000);

        apply_setting(t_cfg'{1'b1, 4'd15, 6'd32, 6'd32, 4'd0, 16'h0000, 16'h0001});
        ask(1'b1, 32'h0000_0000);
        ask(1'b1, 32'h0000_0001);
        ask(1'b0, 32'h0000_0000);

        apply_setting(t_cfg'{1'b1, 4'd2, 6'd10, 6'd4, 4'd0, 16'hfff0, 16'h0001});
        ask(1'b1, 32'h0000_0001);
        ask(1'b1, 32'h0000_0003);
        ask(1'b0, 32'h0000_0000);

        apply_setting(t_cfg'{1'b1, 4'd1, 6'd3, 6'd10, 4'd0, 16'hfffe, 16'h0001});
        ask(1'b1, 32'h0000_0000);
        ask(1'b0, 32'h0000_0000);

        apply_setting(t_cfg'{1'b1, 4'd4, 6'd32, 6'd0, 4'd1, 16'h1000, 16'h0001});
        ask(1'b0, 32'h7fff_ffff);
        ask(1'b0, 32'hffff_ffff);
        ask(1'b1, 32'h0000_0000);

        apply_setting(t_cfg'{1'b1, 4'd15, 6'd32, 6'd1, 4'd0, 16'h0100, 16'h0001});
        ask(1'b1, 32'h0000_0000);

        apply_setting(t_cfg'{1'b0, 4'd0, 6'd0, 6'd0, 4'd15, 16'hffff, 16'hffff});
        load_pool(16'hffff, 16'd2);
        ask(1'b1, 32'h0000_0000);
        ask(1'b0, 32'hffff_ffff);
        ask(1'b1, 32'h0000_0000);
        send_request(OP_LOAD, 1'b0, 32'h0000_0000, 16'h0000, 16'h0000);
        ask(1'b0, 32'h0000_0000);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p >= RANDOM_PHASES - 2) begin
                send_odds  = 0;
                stall_odds = 0;
            end else begin
                send_odds  = $urandom_range(0, 3);
                stall_odds = $urandom_range(0, 3);
            end
            apply_setting(random_setting());
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (p < RANDOM_PHASES - 2 && $urandom_range(0, 99) == 0) hold_until_drained();
                random_request();
            end
        end

        i_valid <= 1'b0;
        for (int w = 0; w < 4000 && ledger.pending.size() != 0; w++) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (ledger.pending.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, ledger.pending.size());
            ledger.n_errors += ledger.pending.size();
        end
        $display("summary: %0d results checked over %0d settings, %0d granted, %0d permit clears",
                 ledger.n_checked, n_settings, ledger.n_granted, ledger.n_cleared);
        $display("summary: %0d pool loads, %0d errors", ledger.n_loads, ledger.n_errors);
        if (ledger.n_errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("%0t: timeout", $time);
        $display("tb: errors");
        $finish;
    end

endmodule
